// ===== design/gks_pkg.sv =====
// Package: shared constants, types and codes for the graph key search block.
`default_nettype none
package gks_pkg;
	localparam int MAX_NODES  = 64;
	localparam int NODE_W     = $clog2(MAX_NODES);
	localparam int CNT_W      = NODE_W + 1;
	localparam int KEY_W      = 64;
	localparam int WORK_DEPTH = 4096;
	localparam int WPTR_W     = $clog2(WORK_DEPTH);
	localparam int WCNT_W     = WPTR_W + 1;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [1:0] {
		ACT_KEY    = 2'd0,
		ACT_EDGE   = 2'd1,
		ACT_SEARCH = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NODE_COUNT  = 2'd0,
		REG_SEARCH_MODE = 2'd1,
		REG_SPARE2      = 2'd2,
		REG_SPARE3      = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KEY,
		ST_EDGE_RDA,
		ST_EDGE_WRA,
		ST_EDGE_RDB,
		ST_EDGE_WRB,
		ST_INIT,
		ST_POP,
		ST_WAIT,
		ST_FETCH,
		ST_CHECK,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic key_wr;
		logic sel_b;
		logic sel_node;
		logic row_wr;
		logic init;
		logic pop;
		logic node_ld;
		logic mark_node;
		logic row_ld;
		logic scan_step;
		logic res_hit;
		logic res_miss;
		logic out_ld;
	} dp_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic list_avail;
		logic skip_node;
		logic key_hit;
		logic scan_done;
		logic out_busy;
	} dp_stat_t;
endpackage
`default_nettype wire

// ===== design/gks_datapath.sv =====
// Datapath: key, adjacency and work-list memories, visit marks, result register.
`default_nettype none
module gks_datapath import gks_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dp_cmd_t              cmd,
	output dp_stat_t                  stat,
	input  wire logic [NODE_W-1:0]    node_index,
	input  wire logic [NODE_W-1:0]    neighbor_index,
	input  wire logic                 edge_on,
	input  wire logic [KEY_W-1:0]     key_value,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]     cfg_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      found,
	output logic [NODE_W-1:0]         found_node
);
	logic [NODE_W-1:0] a_q, b_q, node_q, res_node_q, work_rd_q;
	logic              on_q, mode_q, res_found_q, vld_rd_q;
	logic [KEY_W-1:0]  key_q, key_rd_q;
	logic [CNT_W-1:0]  node_count_q, n_eff, i_q;
	logic [WCNT_W-1:0] head_q, tail_q, tail_dec;
	logic [MAX_NODES-1:0] visited_q, row_valid_q, row_q, adj_rd_q, row_cur, row_new;
	logic [NODE_W-1:0] row_addr, bit_sel, work_waddr_bits;
	logic [WPTR_W-1:0] work_raddr, work_waddr;
	logic              push_cond, push_ok;

	logic [KEY_W-1:0]     key_mem  [MAX_NODES];
	logic [MAX_NODES-1:0] adj_mem  [MAX_NODES];
	logic [NODE_W-1:0]    work_mem [WORK_DEPTH];

	assign n_eff    = (node_count_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_q;
	assign row_addr = cmd.sel_b ? b_q : (cmd.sel_node ? node_q : a_q);
	assign bit_sel  = cmd.sel_b ? a_q : b_q;
	assign row_cur  = vld_rd_q ? adj_rd_q : '0;
	always_comb begin
		row_new          = row_cur;
		row_new[bit_sel] = on_q;
	end
	assign tail_dec   = tail_q - WCNT_W'(1);
	assign work_raddr = mode_q ? tail_dec[WPTR_W-1:0] : head_q[WPTR_W-1:0];
	assign push_cond  = row_q[i_q[NODE_W-1:0]] && !visited_q[i_q[NODE_W-1:0]];
	assign push_ok    = push_cond && !tail_q[WPTR_W];
	assign work_waddr_bits = cmd.init ? '0 : i_q[NODE_W-1:0];
	assign work_waddr      = cmd.init ? '0 : tail_q[WPTR_W-1:0];

	assign stat.n_zero     = (n_eff == '0);
	assign stat.list_avail = mode_q ? (tail_q != '0) : (head_q < tail_q);
	assign stat.skip_node  = mode_q && visited_q[node_q];
	assign stat.key_hit    = (key_rd_q == key_q);
	assign stat.scan_done  = (i_q == n_eff);
	assign stat.out_busy   = out_valid;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			a_q   <= node_index;
			b_q   <= neighbor_index;
			on_q  <= edge_on;
			key_q <= key_value;
		end
		if (cmd.node_ld)
			node_q <= work_rd_q;
		if (cmd.row_ld)
			row_q <= row_cur;
		if (cmd.res_hit) begin
			res_found_q <= 1'b1;
			res_node_q  <= node_q;
		end else if (cmd.res_miss) begin
			res_found_q <= 1'b0;
			res_node_q  <= '0;
		end
		if (cmd.out_ld) begin
			found      <= res_found_q;
			found_node <= res_node_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.key_wr)
			key_mem[a_q] <= key_q;
		key_rd_q <= key_mem[node_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.row_wr)
			adj_mem[row_addr] <= row_new;
		adj_rd_q <= adj_mem[row_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.init || (cmd.scan_step && push_ok))
			work_mem[work_waddr] <= work_waddr_bits;
		work_rd_q <= work_mem[work_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(1);
			mode_q       <= 1'b0;
			row_valid_q  <= '0;
			vld_rd_q     <= 1'b0;
			visited_q    <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			i_q          <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_NODE_COUNT:  node_count_q <= cfg_data;
					REG_SEARCH_MODE: mode_q       <= cfg_data[0];
					default: ;
				endcase
			end
			vld_rd_q <= row_valid_q[row_addr];
			if (cmd.row_wr)
				row_valid_q[row_addr] <= 1'b1;
			if (cmd.init) begin
				visited_q <= {{(MAX_NODES-1){1'b0}}, !mode_q};
				head_q    <= '0;
				tail_q    <= WCNT_W'(1);
			end
			if (cmd.pop) begin
				if (mode_q)
					tail_q <= tail_dec;
				else
					head_q <= head_q + WCNT_W'(1);
			end
			if (cmd.mark_node)
				visited_q[node_q] <= 1'b1;
			if (cmd.row_ld)
				i_q <= '0;
			if (cmd.scan_step) begin
				i_q <= i_q + CNT_W'(1);
				if (push_ok)
					tail_q <= tail_q + WCNT_W'(1);
				if (push_cond && !mode_q)
					visited_q[i_q[NODE_W-1:0]] <= 1'b1;
			end
			if (cmd.out_ld)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== design/gks_ctrl.sv =====
// Controller: sequences loads, edge updates and the graph walk.
`default_nettype none
module gks_ctrl import gks_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] action,
	output logic            in_ready,
	input  wire dp_stat_t   stat,
	output dp_cmd_t         cmd
);
	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (action_t'(action))
						ACT_KEY:    state_nx = ST_KEY;
						ACT_EDGE:   state_nx = ST_EDGE_RDA;
						ACT_SEARCH: state_nx = ST_INIT;
						default:    state_nx = ST_IDLE;
					endcase
				end
			end
			ST_KEY:      state_nx = ST_IDLE;
			ST_EDGE_RDA: state_nx = ST_EDGE_WRA;
			ST_EDGE_WRA: state_nx = ST_EDGE_RDB;
			ST_EDGE_RDB: state_nx = ST_EDGE_WRB;
			ST_EDGE_WRB: state_nx = ST_IDLE;
			ST_INIT:     state_nx = stat.n_zero ? ST_DONE : ST_POP;
			ST_POP:      state_nx = stat.list_avail ? ST_WAIT : ST_DONE;
			ST_WAIT:     state_nx = ST_FETCH;
			ST_FETCH:    state_nx = stat.skip_node ? ST_POP : ST_CHECK;
			ST_CHECK:    state_nx = stat.key_hit ? ST_DONE : ST_SCAN;
			ST_SCAN:     state_nx = stat.scan_done ? ST_POP : ST_SCAN;
			ST_DONE:     state_nx = stat.out_busy ? ST_DONE : ST_IDLE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:     cmd.accept = in_valid;
			ST_KEY:      cmd.key_wr = 1'b1;
			ST_EDGE_RDA: ;
			ST_EDGE_WRA: cmd.row_wr = 1'b1;
			ST_EDGE_RDB: cmd.sel_b = 1'b1;
			ST_EDGE_WRB: begin
				cmd.sel_b  = 1'b1;
				cmd.row_wr = 1'b1;
			end
			ST_INIT: begin
				cmd.init     = 1'b1;
				cmd.res_miss = 1'b1;
			end
			ST_POP: begin
				cmd.pop      = stat.list_avail;
				cmd.res_miss = 1'b1;
			end
			ST_WAIT:     cmd.node_ld = 1'b1;
			ST_FETCH: begin
				cmd.sel_node  = 1'b1;
				cmd.mark_node = !stat.skip_node;
			end
			ST_CHECK: begin
				cmd.res_hit = stat.key_hit;
				cmd.row_ld  = !stat.key_hit;
			end
			ST_SCAN:     cmd.scan_step = !stat.scan_done;
			ST_DONE:     cmd.out_ld = !stat.out_busy;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== design/graph_key_search_bfs_dfs.sv =====
// Top level: graph key search by breadth-first or depth-first walk.
// Edge write: two row read-modify-writes, one per end of the edge.
// Search: each expanded node is fetched, checked against the key and
// scanned for neighbours; depth-first duplicates are skipped. One item at a time.
// Reset (arst_n low, asynchronous): no edges, node_count 1, breadth-first,
// no result pending. Node keys are undefined until written.
`default_nettype none
module graph_key_search_bfs_dfs import gks_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           action,
	input  wire logic [NODE_W-1:0]    node_index,
	input  wire logic [NODE_W-1:0]    neighbor_index,
	input  wire logic                 edge_on,
	input  wire logic [KEY_W-1:0]     key_value,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      found,
	output logic [NODE_W-1:0]         found_node,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]     cfg_data
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	gks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gks_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.node_index     (node_index),
		.neighbor_index (neighbor_index),
		.edge_on        (edge_on),
		.key_value      (key_value),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.found          (found),
		.found_node     (found_node)
	);
endmodule
`default_nettype wire

// ===== design/gks_checker.sv =====
// Checker: port-level assertions for the graph key search block, with bind.
`default_nettype none
module gks_checker import gks_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic [1:0]        action,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic              found,
	input wire logic [NODE_W-1:0] found_node
);
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> found_node == '0)
		else $error("not-found result with nonzero node");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(found_node))
		else $error("result dropped or changed while stalled");

	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_SEARCH |=> !in_ready ##1 !in_ready)
		else $error("input taken during search setup");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action != ACT_SEARCH && !out_valid |=> !out_valid)
		else $error("result without a search");
endmodule

bind graph_key_search_bfs_dfs gks_checker u_gks_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.action     (action),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.found      (found),
	.found_node (found_node)
);
`default_nettype wire
